/* rtl/core/dbh_pkg.sv */
// ----------------------------------------------------------------------------
// Deadband with hysteresis package
// Shared widths, register indexes, side codes and interface structs.
// ----------------------------------------------------------------------------
package dbh_pkg;

  localparam int SampleW = 32;
  localparam int WidthW  = 31;
  localparam int CfgIdxW = 2;
  localparam int XW      = SampleW + 1;
  localparam int RW      = SampleW + 2;
  localparam int SumW    = SampleW + 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDeadband = 2'd0,
    CfgHyst     = 2'd1,
    CfgOffset   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SideInside = 2'd0,
    SidePos    = 2'd1,
    SideNeg    = 2'd2
  } side_e;

  typedef struct packed {
    logic [WidthW-1:0]         width;
    logic [WidthW-1:0]         gap;
    logic                      hyst_zero;
    logic signed [SampleW-1:0] offset;
  } cfg_t;

  typedef struct packed {
    logic gt_d;
    logic ge_d;
    logic lt_nd;
    logic le_nd;
    logic in_gap;
    logic pos;
    logic neg;
  } flags_t;

  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
  } pipe_ld_t;

endpackage

/* rtl/core/deadband_with_hysteresis_top.sv */
// ----------------------------------------------------------------------------
// Deadband with hysteresis top level
// An accepted word passes the offset, compare, side and saturate registers in turn before its result word is valid.
// Throughput is one word per cycle while the output is not stalled; the side register updates once per word.
// Reset empties the pipeline, zeroes all three registers and sets the side
// to inside.
// ----------------------------------------------------------------------------
module deadband_with_hysteresis_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dbh_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [dbh_pkg::SampleW-1:0]        cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [dbh_pkg::SampleW-1:0] sample_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [dbh_pkg::SampleW-1:0] filtered_o
);
  import dbh_pkg::*;

  cfg_t                 cfg;
  logic                 side_clr;
  pipe_ld_t             ld;
  flags_t               flags;
  logic signed [RW-1:0] x_m;
  logic signed [RW-1:0] x_p;
  logic signed [RW-1:0] r;

  dbh_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .side_clr_o  (side_clr)
  );

  dbh_flow u_flow (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ld_o        (ld)
  );

  dbh_classify u_classify (
    .clk_i    (clk_i),
    .ld_i     (ld),
    .sample_i (sample_i),
    .cfg_i    (cfg),
    .x_m_o    (x_m),
    .x_p_o    (x_p),
    .flags_o  (flags)
  );

  dbh_side u_side (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ld_i        (ld),
    .side_clr_i  (side_clr),
    .hyst_zero_i (cfg.hyst_zero),
    .flags_i     (flags),
    .x_m_i       (x_m),
    .x_p_i       (x_p),
    .r_o         (r)
  );

  dbh_sat u_sat (
    .clk_i      (clk_i),
    .ld_i       (ld),
    .r_i        (r),
    .offset_i   (cfg.offset),
    .filtered_o (filtered_o)
  );

endmodule

/* rtl/core/dbh_cfg.sv */
// ----------------------------------------------------------------------------
// Deadband with hysteresis configuration registers
// Holds width, hysteresis and offset, and keeps the derived gap registered.
// ----------------------------------------------------------------------------
module dbh_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dbh_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dbh_pkg::SampleW-1:0]   cfg_wdata_i,
  output dbh_pkg::cfg_t                 cfg_o,
  output logic                          side_clr_o
);
  import dbh_pkg::*;

  logic [WidthW-1:0]         width_q;
  logic [WidthW-1:0]         hyst_q;
  logic signed [SampleW-1:0] offset_q;
  logic [WidthW-1:0]         eff_hyst;
  logic [WidthW-1:0]         gap_d;
  logic [WidthW-1:0]         gap_q;
  logic                      hz_d;
  logic                      hz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      hyst_q   <= '0;
      offset_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDeadband: width_q  <= cfg_wdata_i[WidthW-1:0];
        CfgHyst:     hyst_q   <= cfg_wdata_i[WidthW-1:0];
        CfgOffset:   offset_q <= $signed(cfg_wdata_i);
        default: begin
        end
      endcase
    end
  end

  // The effective hysteresis never exceeds the deadband width.
  assign eff_hyst = (hyst_q < width_q) ? hyst_q : width_q;
  assign gap_d    = width_q - eff_hyst;
  assign hz_d     = (eff_hyst == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= '0;
      hz_q  <= 1'b1;
    end else begin
      gap_q <= gap_d;
      hz_q  <= hz_d;
    end
  end

  assign side_clr_o = cfg_we_i &&
                      ((cfg_idx_i == CfgDeadband) || (cfg_idx_i == CfgHyst));

  assign cfg_o.width     = width_q;
  assign cfg_o.gap       = gap_q;
  assign cfg_o.hyst_zero = hz_q;
  assign cfg_o.offset    = offset_q;

endmodule

/* rtl/core/dbh_flow.sv */
// ----------------------------------------------------------------------------
// Deadband with hysteresis flow control
// Tracks the valid bit of each pipeline stage and issues the load enables.
// ----------------------------------------------------------------------------
module dbh_flow (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dbh_pkg::pipe_ld_t ld_o
);
  import dbh_pkg::*;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  // A stage can take a word when it is empty or its word moves on.
  assign rdy4 = !v4_q || !out_stall_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  assign ld_o.ld1    = in_valid_i && rdy1;
  assign ld_o.ld2    = v1_q && rdy2;
  assign ld_o.ld3    = v2_q && rdy3;
  assign ld_o.ld4    = v3_q && rdy4;
  assign in_stall_o  = !rdy1;
  assign out_valid_o = v4_q;

endmodule

/* rtl/core/dbh_classify.sv */
// ----------------------------------------------------------------------------
// Deadband with hysteresis classifier
// Removes the offset, then compares against the bounds and forms both
// gap-shifted candidates.
// ----------------------------------------------------------------------------
module dbh_classify (
  input  logic                               clk_i,
  input  dbh_pkg::pipe_ld_t                  ld_i,
  input  logic signed [dbh_pkg::SampleW-1:0] sample_i,
  input  dbh_pkg::cfg_t                      cfg_i,
  output logic signed [dbh_pkg::RW-1:0]      x_m_o,
  output logic signed [dbh_pkg::RW-1:0]      x_p_o,
  output dbh_pkg::flags_t                    flags_o
);
  import dbh_pkg::*;

  logic signed [XW-1:0] x_d;
  logic signed [XW-1:0] x_q;
  logic signed [RW-1:0] xe;
  logic signed [RW-1:0] dz;
  logic signed [RW-1:0] gz;
  flags_t               flags_d;
  flags_t               flags_q;
  logic signed [RW-1:0] x_m_q;
  logic signed [RW-1:0] x_p_q;

  assign x_d = $signed({sample_i[SampleW-1], sample_i}) -
               $signed({cfg_i.offset[SampleW-1], cfg_i.offset});

  always_ff @(posedge clk_i) begin
    if (ld_i.ld1) begin
      x_q <= x_d;
    end
  end

  assign xe = $signed({x_q[XW-1], x_q});
  assign dz = $signed({{(RW-WidthW){1'b0}}, cfg_i.width});
  assign gz = $signed({{(RW-WidthW){1'b0}}, cfg_i.gap});

  always_comb begin
    flags_d.gt_d   = xe > dz;
    flags_d.ge_d   = xe >= dz;
    flags_d.lt_nd  = xe < -dz;
    flags_d.le_nd  = xe <= -dz;
    flags_d.in_gap = (xe <= gz) && (xe >= -gz);
    flags_d.pos    = xe > $signed({RW{1'b0}});
    flags_d.neg    = xe[RW-1];
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.ld2) begin
      flags_q <= flags_d;
      x_m_q   <= xe - gz;
      x_p_q   <= xe + gz;
    end
  end

  assign x_m_o   = x_m_q;
  assign x_p_o   = x_p_q;
  assign flags_o = flags_q;

endmodule

/* rtl/core/dbh_side.sv */
// ----------------------------------------------------------------------------
// Deadband with hysteresis side tracker
// Holds the side state and picks the shifted value or zero for each word.
// ----------------------------------------------------------------------------
module dbh_side (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dbh_pkg::pipe_ld_t             ld_i,
  input  logic                          side_clr_i,
  input  logic                          hyst_zero_i,
  input  dbh_pkg::flags_t               flags_i,
  input  logic signed [dbh_pkg::RW-1:0] x_m_i,
  input  logic signed [dbh_pkg::RW-1:0] x_p_i,
  output logic signed [dbh_pkg::RW-1:0] r_o
);
  import dbh_pkg::*;

  side_e                side_q;
  side_e                side_d;
  logic signed [RW-1:0] r_d;
  logic signed [RW-1:0] r_q;
  logic                 mag_le_d;

  assign mag_le_d = !flags_i.gt_d && !flags_i.lt_nd;

  always_comb begin
    side_d = side_q;
    r_d    = '0;
    if (mag_le_d && (hyst_zero_i || (side_q == SideInside))) begin
      r_d = '0;
    end else if (hyst_zero_i) begin
      r_d = flags_i.gt_d ? x_m_i : x_p_i;
    end else if (flags_i.ge_d) begin
      r_d    = x_m_i;
      side_d = SidePos;
    end else if (flags_i.le_nd) begin
      r_d    = x_p_i;
      side_d = SideNeg;
    end else if (flags_i.in_gap) begin
      r_d    = '0;
      side_d = SideInside;
    end else if (flags_i.pos && (side_q == SidePos)) begin
      r_d = x_m_i;
    end else if (flags_i.neg && (side_q == SideNeg)) begin
      r_d = x_p_i;
    end else begin
      r_d    = '0;
      side_d = SideInside;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SideInside;
    end else if (side_clr_i) begin
      side_q <= SideInside;
    end else if (ld_i.ld3) begin
      side_q <= side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.ld3) begin
      r_q <= r_d;
    end
  end

  assign r_o = r_q;

endmodule

/* rtl/core/dbh_sat.sv */
// ----------------------------------------------------------------------------
// Deadband with hysteresis output stage
// Adds the offset back and clamps the sum to the signed 32-bit range.
// ----------------------------------------------------------------------------
module dbh_sat (
  input  logic                               clk_i,
  input  dbh_pkg::pipe_ld_t                  ld_i,
  input  logic signed [dbh_pkg::RW-1:0]      r_i,
  input  logic signed [dbh_pkg::SampleW-1:0] offset_i,
  output logic signed [dbh_pkg::SampleW-1:0] filtered_o
);
  import dbh_pkg::*;

  logic signed [SumW-1:0]    sum;
  logic signed [SampleW-1:0] sat_d;
  logic signed [SampleW-1:0] filtered_q;
  logic                      in_range;

  assign sum = $signed({r_i[RW-1], r_i}) +
               $signed({{(SumW-SampleW){offset_i[SampleW-1]}}, offset_i});

  assign in_range = (sum[SumW-1:SampleW-1] == '0) || (sum[SumW-1:SampleW-1] == '1);

  always_comb begin
    if (in_range) begin
      sat_d = sum[SampleW-1:0];
    end else if (sum[SumW-1]) begin
      sat_d = {1'b1, {(SampleW-1){1'b0}}};
    end else begin
      sat_d = {1'b0, {(SampleW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.ld4) begin
      filtered_q <= sat_d;
    end
  end

  assign filtered_o = filtered_q;

endmodule

/* rtl/core/dbh_checker.sv */
// ----------------------------------------------------------------------------
// Deadband with hysteresis port checker
// Watches the top-level ports for handshake and pipeline timing properties.
// ----------------------------------------------------------------------------
module dbh_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic signed [dbh_pkg::SampleW-1:0] filtered_o
);
  import dbh_pkg::*;

  logic in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  // A result word that is stalled stays valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(filtered_o))
    else $error("result word changed while stalled");

  // The input side only stalls when the pipeline is full behind a held result.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with room in the pipeline");

  // With the output free, an accepted word moves through every stage register and shows up as a valid result word.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(in_acc, 4) && $past(rst_ni, 4) && $past(rst_ni, 3) &&
    $past(rst_ni, 2) && $past(rst_ni, 1) && !$past(out_stall_i, 3) &&
    !$past(out_stall_i, 2) && !$past(out_stall_i, 1) |-> out_valid_o)
    else $error("accepted word did not reach the output in time");

endmodule

bind deadband_with_hysteresis_top dbh_checker u_dbh_checker (.*);

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// Deadband with hysteresis testbench
// Drives samples through the block across several register settings under
// mixed idle and stall patterns. A scoreboard class predicts each filtered
// word, including the side register, and compares it in order of arrival.
// ----------------------------------------------------------------------------
module tb;
  import dbh_pkg::*;

  localparam int Latency       = 4;
  localparam int WatchdogLimit = 2000;
  localparam int HoldCycles    = 200;
  localparam int PhaseWords    = 165;
  localparam int MaxPrinted    = 100;

  localparam logic [CfgIdxW-1:0] CfgBadIdx = 2'd3;

  localparam longint SatMax   = 64'sd2147483647;
  localparam longint SatMin   = -64'sd2147483648;
  localparam longint DirWidth = 64'sh10_0000;
  localparam longint DirGap   = 64'sh0C_0000;

  typedef enum int {PressNone, PressHold, PressPause} pressure_e;

  class filter_scoreboard;
    logic [WidthW-1:0]         width_q;
    logic [WidthW-1:0]         hyst_q;
    logic signed [SampleW-1:0] offset_q;
    side_e                     side_q;
    logic signed [SampleW-1:0] expected_q[$];
    int                        n_in;
    int                        n_out;
    int                        n_errors;

    function new();
      width_q  = '0;
      hyst_q   = '0;
      offset_q = '0;
      side_q   = SideInside;
      n_in     = 0;
      n_out    = 0;
      n_errors = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [SampleW-1:0] data);
      case (idx)
        CfgDeadband: begin
          width_q = data[WidthW-1:0];
          side_q  = SideInside;
        end
        CfgHyst: begin
          hyst_q = data[WidthW-1:0];
          side_q = SideInside;
        end
        CfgOffset: begin
          offset_q = data;
        end
        default: begin
        end
      endcase
    endfunction

    function logic signed [SampleW-1:0] filter(logic signed [SampleW-1:0] s);
      longint     d;
      longint     e;
      longint     gap;
      longint     x;
      longint     r;
      longint     y;
      logic [63:0] y_bits;
      d = width_q;
      e = hyst_q;
      if (e > d) e = d;
      gap = d - e;
      x   = s;
      x   = x - offset_q;
      if (((x < 0) ? -x : x) <= d && (e == 0 || side_q == SideInside)) begin
        r = 0;
      end else if (e == 0) begin
        r = (x > d) ? x - d : x + d;
      end else if (e == d) begin
        if (x >= d) begin
          r      = x;
          side_q = SidePos;
        end else if (x <= -d) begin
          r      = x;
          side_q = SideNeg;
        end else if (side_q == SidePos && x > 0) begin
          r = x;
        end else if (side_q == SideNeg && x < 0) begin
          r = x;
        end else begin
          r      = 0;
          side_q = SideInside;
        end
      end else begin
        if (x >= d) begin
          r      = x - gap;
          side_q = SidePos;
        end else if (x <= -d) begin
          r      = x + gap;
          side_q = SideNeg;
        end else if (((x < 0) ? -x : x) <= gap) begin
          r      = 0;
          side_q = SideInside;
        end else if (x > 0 && side_q == SidePos) begin
          r = x - gap;
        end else if (x < 0 && side_q == SideNeg) begin
          r = x + gap;
        end else begin
          r      = 0;
          side_q = SideInside;
        end
      end
      y = r + offset_q;
      if (y > SatMax) y = SatMax;
      if (y < SatMin) y = SatMin;
      y_bits = y;
      return y_bits[SampleW-1:0];
    endfunction

    function void note_sample(logic signed [SampleW-1:0] s);
      expected_q.push_back(filter(s));
      n_in++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      n_errors++;
      if (n_errors <= MaxPrinted) $display("MISMATCH: %s", msg);
    endtask

    task check_filtered(logic signed [SampleW-1:0] got);
      logic signed [SampleW-1:0] want;
      if (expected_q.size() == 0) begin
        report($sformatf("filtered word %08h arrived with none expected", got));
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          report($sformatf("word %0d: filtered %08h, expected %08h", n_out, got, want));
        end
        n_out++;
      end
    endtask
  endclass

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]        cfg_idx_i   = '0;
  logic [SampleW-1:0]        cfg_wdata_i = '0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_stall_o;
  logic signed [SampleW-1:0] sample_i    = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [SampleW-1:0] filtered_o;

  int               idle_pct   = 0;
  int               stall_pct  = 0;
  int               n_settings = 0;
  bit               hold_req   = 1'b0;
  longint           walk_x     = 0;
  filter_scoreboard sb         = new();

  deadband_with_hysteresis_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .filtered_o  (filtered_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_sample(sample_i);
      if (out_valid_o && !out_stall_i) sb.check_filtered(filtered_o);
    end
  end

  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timeout: no word moved for %0d cycles.", WatchdogLimit);
    $display("** deadband_with_hysteresis_top: FAILED **");
    $finish;
  end

  task automatic send_sample(input logic signed [SampleW-1:0] value);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i <= 1'b1;
    sample_i   <= value;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_rel(input longint x);
    longint t;
    t = sb.offset_q;
    t = t + x;
    send_sample(t[SampleW-1:0]);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic settle();
    drain();
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [SampleW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic end_writes();
    cfg_we_i <= 1'b0;
    n_settings++;
    @(posedge clk_i);
  endtask

  // Mostly a random walk around the band so that the side register sees full
  // excursions and returns, mixed with edge hits and raw noise.
  function automatic logic signed [SampleW-1:0] pick_sample();
    longint      d;
    longint      e;
    longint      gap;
    longint      span;
    longint      q;
    longint      u;
    longint      x;
    longint      t;
    int unsigned sel;
    d = sb.width_q;
    e = sb.hyst_q;
    if (e > d) e = d;
    gap  = d - e;
    span = (d > 0) ? d : 64;
    sel  = $urandom_range(99);
    if (sel >= 95) return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    if (sel >= 85) return $urandom;
    if (sel < 60) begin
      if ($urandom_range(9) == 0) begin
        walk_x = d + int'($urandom_range(15));
        if ($urandom_range(1)) walk_x = -walk_x;
      end else begin
        q      = span / 3 + 1;
        u      = $urandom;
        walk_x = walk_x + (u % (2 * q + 1)) - q;
        if (walk_x > 2 * span || walk_x < -2 * span) walk_x = walk_x / 4;
      end
      x = walk_x;
    end else begin
      case ($urandom_range(5))
        0:       x = 0;
        1:       x = d;
        2:       x = d + 1;
        3:       x = gap;
        4:       x = gap + 1;
        default: x = d - 1;
      endcase
      if ($urandom_range(1)) x = -x;
    end
    t = sb.offset_q;
    t = t + x;
    return t[SampleW-1:0];
  endfunction

  task automatic run_directed();
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h0000_0000);
    send_sample(32'h0000_0001);
    send_sample(32'hFFFF_FFFF);

    settle();
    write_reg(CfgDeadband, 32'h0010_0000);
    write_reg(CfgHyst, 32'h0004_0000);
    write_reg(CfgOffset, 32'h0002_0000);
    end_writes();
    send_rel(0);
    send_rel(DirWidth);
    send_rel(DirGap + 1);
    send_rel(-DirGap - 1);
    send_rel(DirGap + 1);
    send_rel(-DirWidth);
    send_rel(-DirGap - 1);
    send_rel(DirGap);
    send_rel(DirWidth);

    // A hysteresis write must drop the side back to inside.
    settle();
    write_reg(CfgHyst, 32'h0010_0000);
    end_writes();
    send_rel(1);
    send_rel(DirWidth);
    send_rel(1);
    send_rel(-1);
    send_rel(-DirWidth - 1);

    // An offset write and a write to an unused index keep the side.
    settle();
    write_reg(CfgOffset, 32'hFFFF_0000);
    write_reg(CfgBadIdx, 32'h1234_5678);
    end_writes();
    send_rel(-1);
    settle();
    write_reg(CfgDeadband, 32'h0010_0000);
    end_writes();
    send_rel(-1);

    settle();
    write_reg(CfgDeadband, 32'hFFFF_FFFF);
    write_reg(CfgHyst, 32'h0000_0000);
    write_reg(CfgOffset, 32'h8000_0000);
    end_writes();
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'h0000_0000);
  endtask

  task automatic run_phase(input logic [SampleW-1:0] width, hyst, offset,
                           input int idle, stall, input pressure_e pressure);
    settle();
    write_reg(CfgDeadband, width);
    write_reg(CfgHyst, hyst);
    write_reg(CfgOffset, offset);
    end_writes();
    idle_pct  = idle;
    stall_pct = stall;
    walk_x    = 0;
    for (int i = 0; i < PhaseWords; i++) begin
      if (pressure == PressHold && i == 40) hold_req = 1'b1;
      if (pressure == PressPause && i == 80) drain();
      send_sample(pick_sample());
    end
  endtask

  initial begin : stimulus
    logic [SampleW-1:0] d;
    logic [SampleW-1:0] e;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    d = $urandom_range(32'h0004_0000, 16);
    run_phase(d, 32'h0, $urandom, 0, 0, PressNone);
    d = $urandom_range(32'h0040_0000, 16);
    e = $urandom_range(d - 1, 1);
    run_phase(d, e, $urandom, 78, 0, PressNone);
    d = $urandom_range(32'h0040_0000, 16);
    run_phase(d, d, $urandom, 0, 78, PressNone);
    run_phase(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 31, 31, PressNone);
    d = $urandom_range(32'h0010_0000, 16);
    run_phase(d, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 0, PressHold);
    run_phase(32'h0, $urandom, $urandom, 31, 31, PressNone);
    run_phase(32'h2, 32'h1, 32'h0, 31, 31, PressPause);
    d = $urandom_range(32'h7FFF_FFFF, 32'h0100_0000);
    e = $urandom_range(d - 1, 1);
    run_phase(d, e, $urandom, 0, 78, PressHold);

    drain();
    repeat (Latency + 4) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d expected words never arrived", sb.pending()));
    end
    $display("Sent %0d samples and checked %0d filtered words over %0d register settings,",
             sb.n_in, sb.n_out, n_settings);
    $display("covering plain, bowtie and partial hysteresis with idle, stall and hold-off.");
    if (sb.n_errors == 0) begin
      $display("** deadband_with_hysteresis_top: PASSED **");
    end else begin
      $display("** deadband_with_hysteresis_top: FAILED **");
    end
    $finish;
  end

endmodule
